@@ rtl/pdir_pkg.sv @@
`timescale 1ns / 1ps

package pdir_pkg;

    // Field widths of the input and result items.
    localparam int INTERVAL_W = 24;
    localparam int ADDR_W     = 5;
    localparam int CMD_W      = 8;
    localparam int EXTRA_W    = 2;
    localparam int MSG_W      = ADDR_W + CMD_W + EXTRA_W;

    // Packet framing.
    localparam int PACKET_BITS = 15;
    localparam int BCNT_W      = 4;

    // Message check patterns between the normal and inverted packets.
    localparam logic [CMD_W-1:0]   CMD_CHECK   = 8'hFF;
    localparam logic [EXTRA_W-1:0] EXTRA_CHECK = 2'h3;

    // Item modes.
    localparam logic MODE_EDGE = 1'b0;
    localparam logic MODE_READ = 1'b1;

    // Configuration port.
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = INTERVAL_W;

    localparam logic [CFG_IDX_W-1:0] CFG_BIT_THRESHOLD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_BIT       = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MESSAGE_GAP   = 2'd2;

    localparam logic [INTERVAL_W-1:0] RST_BIT_THRESHOLD = 24'd1500;
    localparam logic [INTERVAL_W-1:0] RST_MAX_BIT       = 24'd2500;
    localparam logic [INTERVAL_W-1:0] RST_MESSAGE_GAP   = 24'd30000;

    typedef struct packed {
        logic [INTERVAL_W-1:0] bit_threshold;
        logic [INTERVAL_W-1:0] max_bit_interval;
        logic [INTERVAL_W-1:0] message_gap;
    } t_cfg;

    // A message completed by the current edge.
    typedef struct packed {
        logic             done;
        logic             ok;
        logic [MSG_W-1:0] msg;
    } t_frame;

    // Status flags of one result item.
    typedef struct packed {
        logic msg_valid;
        logic accepted;
        logic dropped;
        logic available;
    } t_ring_status;

endpackage

@@ rtl/pdir_cfg_regs.sv @@
`timescale 1ns / 1ps

module pdir_cfg_regs (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_wr_en,
    input  logic [pdir_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [pdir_pkg::CFG_DATA_W-1:0] i_cfg_wdata,
    output pdir_pkg::t_cfg                 o_cfg
);
    import pdir_pkg::*;

    t_cfg r_cfg;

    // Register writes; an index beyond the list is ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.bit_threshold    <= RST_BIT_THRESHOLD;
            r_cfg.max_bit_interval <= RST_MAX_BIT;
            r_cfg.message_gap      <= RST_MESSAGE_GAP;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                CFG_BIT_THRESHOLD: r_cfg.bit_threshold    <= i_cfg_wdata;
                CFG_MAX_BIT:       r_cfg.max_bit_interval <= i_cfg_wdata;
                CFG_MESSAGE_GAP:   r_cfg.message_gap      <= i_cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

@@ rtl/pdir_frame_rx.sv @@
`timescale 1ns / 1ps

module pdir_frame_rx (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_step,
    input  logic [pdir_pkg::INTERVAL_W-1:0] i_interval_us,
    input  pdir_pkg::t_cfg                  i_cfg,
    output pdir_pkg::t_frame                o_frame
);
    import pdir_pkg::*;

    logic              r_inv_phase, n_inv_phase;
    logic [BCNT_W-1:0] r_bit_count, n_bit_count;
    logic [MSG_W-1:0]  r_norm, n_norm;
    logic [MSG_W-1:0]  r_inv, n_inv;
    logic              bit_val;
    logic              last_bit;
    logic              done;

    assign bit_val  = (i_interval_us > i_cfg.bit_threshold);
    assign last_bit = (r_bit_count == BCNT_W'(PACKET_BITS - 1));

    // Classify the interval and shift the bit in, first bit ending at bit 0.
    always_comb begin
        n_inv_phase = r_inv_phase;
        n_bit_count = r_bit_count;
        n_norm      = r_norm;
        n_inv       = r_inv;
        done        = 1'b0;
        if (i_step) begin
            if (i_interval_us > i_cfg.message_gap) begin
                n_bit_count = '0;
                n_inv_phase = 1'b0;
            end else if (i_interval_us > i_cfg.max_bit_interval) begin
                n_bit_count = '0;
            end else if (!r_inv_phase) begin
                n_norm = {bit_val, r_norm[MSG_W-1:1]};
                if (last_bit) begin
                    n_bit_count = '0;
                    n_inv_phase = 1'b1;
                end else begin
                    n_bit_count = r_bit_count + 1'b1;
                end
            end else begin
                n_inv = {bit_val, r_inv[MSG_W-1:1]};
                if (last_bit) begin
                    n_bit_count = '0;
                    n_inv_phase = 1'b0;
                    done        = 1'b1;
                end else begin
                    n_bit_count = r_bit_count + 1'b1;
                end
            end
        end
    end

    // Control state resets; the shift registers are refilled before use.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inv_phase <= 1'b0;
            r_bit_count <= '0;
        end else begin
            r_inv_phase <= n_inv_phase;
            r_bit_count <= n_bit_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_norm <= n_norm;
        r_inv  <= n_inv;
    end

    // Address must match, command and extra bits must be inverted copies.
    assign o_frame.done = done;
    assign o_frame.msg  = r_norm;
    assign o_frame.ok   =
        (r_norm[ADDR_W-1:0] == n_inv[ADDR_W-1:0]) &&
        ((r_norm[ADDR_W +: CMD_W] ^ n_inv[ADDR_W +: CMD_W]) == CMD_CHECK) &&
        ((r_norm[ADDR_W+CMD_W +: EXTRA_W] ^ n_inv[ADDR_W+CMD_W +: EXTRA_W]) == EXTRA_CHECK);

endmodule

@@ rtl/pdir_msg_ring.sv @@
`timescale 1ns / 1ps

module pdir_msg_ring #(
    parameter int RING_DEPTH = 8
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_step,
    input  logic                       i_pop,
    input  pdir_pkg::t_frame           i_frame,
    output logic [pdir_pkg::MSG_W-1:0] o_msg,
    output pdir_pkg::t_ring_status     o_status
);
    import pdir_pkg::*;

    localparam int IDX_W = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(RING_DEPTH - 1);

    logic [MSG_W-1:0]      mem [RING_DEPTH];
    logic [RING_DEPTH-1:0] r_full, n_full;
    logic [IDX_W-1:0]      r_wr, n_wr;
    logic [IDX_W-1:0]      r_rd, n_rd;
    logic [MSG_W-1:0]      r_msg;
    t_ring_status          r_status, n_status;
    logic                  pop_hit;
    logic                  push_ok;

    assign pop_hit = i_step && i_pop && r_full[r_rd];
    assign push_ok = i_frame.done && i_frame.ok && !r_full[r_wr];

    // Pointer and occupancy update; a read of an empty ring leaves it alone.
    always_comb begin
        n_full = r_full;
        n_wr   = r_wr;
        n_rd   = r_rd;
        if (pop_hit) begin
            n_full[r_rd] = 1'b0;
            n_rd         = (r_rd == LAST_IDX) ? '0 : r_rd + 1'b1;
        end
        if (push_ok) begin
            n_full[r_wr] = 1'b1;
            n_wr         = (r_wr == LAST_IDX) ? '0 : r_wr + 1'b1;
        end
        n_status.msg_valid = pop_hit;
        n_status.accepted  = push_ok;
        n_status.dropped   = i_frame.done && !push_ok;
        n_status.available = n_full[n_rd];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_full <= '0;
            r_wr   <= '0;
            r_rd   <= '0;
        end else if (i_step) begin
            r_full <= n_full;
            r_wr   <= n_wr;
            r_rd   <= n_rd;
        end
    end

    // Message storage; the read port loads the result register directly.
    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            mem[r_wr] <= i_frame.msg;
        end
        if (i_step) begin
            if (pop_hit) begin
                r_msg <= mem[r_rd];
            end else begin
                r_msg <= '0;
            end
            r_status <= n_status;
        end
    end

    assign o_msg    = r_msg;
    assign o_status = r_status;

endmodule

@@ rtl/pulse_distance_ir_frame_decoder_top.sv @@
`timescale 1ns / 1ps

// Pulse-distance IR frame decoder with a ring of received messages.
// Input channel (i_in_valid / o_in_ready): each item is either a falling edge
// (i_mode = 0) carrying the microseconds since the previous falling edge, or
// a read request (i_mode = 1) that pops the oldest stored message.
// Output channel (o_out_valid / i_out_ready): exactly one result item per
// input item, carrying the popped message or the frame accept/drop flags and
// whether a message still waits to be read.
// The configuration port writes the bit threshold, the bit interval limit and
// the message gap; write only while the block is idle.
// An item lands in the input register, and the result register is loaded
// from it once free. One item is taken every cycle while the receiver takes
// results; the rate is set by the single pass of compares, shift and ring
// update between them. When the receiver stalls, the result register holds
// and the input register still takes one more item before o_in_ready drops.
// Synchronous reset restores the register defaults, clears the packet state
// and empties the ring; no clearing pass is needed.
module pulse_distance_ir_frame_decoder_top #(
    parameter int RING_DEPTH = 8
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_wr_en,
    input  logic [pdir_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [pdir_pkg::CFG_DATA_W-1:0]   i_cfg_wdata,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic                              i_mode,
    input  logic [pdir_pkg::INTERVAL_W-1:0]   i_interval_us,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic                              o_msg_valid,
    output logic [pdir_pkg::ADDR_W-1:0]       o_address,
    output logic [pdir_pkg::CMD_W-1:0]        o_command,
    output logic [pdir_pkg::EXTRA_W-1:0]      o_extra_bits,
    output logic                              o_frame_accepted,
    output logic                              o_frame_dropped,
    output logic                              o_available
);
    import pdir_pkg::*;

    logic                  r_s1_valid;
    logic                  r_s1_mode;
    logic [INTERVAL_W-1:0] r_s1_interval;
    logic                  r_out_valid;
    logic                  out_free;
    logic                  s2_fire;
    logic                  in_fire;
    t_cfg                  cfg;
    t_frame                frame;
    logic [MSG_W-1:0]      msg;
    t_ring_status          status;

    // Handshake: the result register frees when empty or being taken.
    assign out_free   = !r_out_valid || i_out_ready;
    assign s2_fire    = r_s1_valid && out_free;
    assign o_in_ready = !r_s1_valid || out_free;
    assign in_fire    = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_fire) begin
                r_s1_valid <= 1'b1;
            end else if (s2_fire) begin
                r_s1_valid <= 1'b0;
            end
            if (s2_fire) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Input register.
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_s1_mode     <= i_mode;
            r_s1_interval <= i_interval_us;
        end
    end

    pdir_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (cfg)
    );

    pdir_frame_rx u_rx (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_step        (s2_fire && (r_s1_mode == MODE_EDGE)),
        .i_interval_us (r_s1_interval),
        .i_cfg         (cfg),
        .o_frame       (frame)
    );

    pdir_msg_ring #(
        .RING_DEPTH (RING_DEPTH)
    ) u_ring (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (s2_fire),
        .i_pop    (r_s1_mode == MODE_READ),
        .i_frame  (frame),
        .o_msg    (msg),
        .o_status (status)
    );

    // Result fields.
    assign o_out_valid      = r_out_valid;
    assign o_msg_valid      = status.msg_valid;
    assign o_address        = msg[ADDR_W-1:0];
    assign o_command        = msg[ADDR_W +: CMD_W];
    assign o_extra_bits     = msg[ADDR_W+CMD_W +: EXTRA_W];
    assign o_frame_accepted = status.accepted;
    assign o_frame_dropped  = status.dropped;
    assign o_available      = status.available;

endmodule
